/* rtl/core/orq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// orq_pkg
// Shared types and constants of the ordered ready queue: item field widths,
// operation and status codes, and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package orq_pkg;

  localparam int unsigned ID_W  = 16;
  localparam int unsigned PRI_W = 16;
  localparam int unsigned REM_W = 32;
  localparam int unsigned OCC_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Pointer update; every read is issued at the updated pointer.
  typedef enum logic [2:0] {
    PTR_HOLD = 3'd0,
    PTR_TAIL = 3'd1,
    PTR_ZERO = 3'd2,
    PTR_DEC  = 3'd3,
    PTR_INC  = 3'd4
  } ptr_op_e;

  typedef enum logic [2:0] {
    WR_NONE       = 3'd0,
    WR_FRESH_NEXT = 3'd1,  // new entry at ptr + 1
    WR_SHIFT_UP   = 3'd2,  // read entry to ptr + 1
    WR_SHIFT_DOWN = 3'd3,  // read entry to ptr - 1
    WR_FRESH_ZERO = 3'd4   // new entry at the head
  } wr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [REM_W-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    ptr_op_e ptr_op;
    wr_op_e  wr_op;
    logic    cap_hit;
    logic    finish;
    status_e status;
    cnt_op_e cnt_op;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic cnt_zero;
    logic cnt_full;
    logic ptr_zero;
    logic ptr_last;
    logic ahead;
    logic id_match;
  } dp_status_t;

endpackage
`default_nettype wire

/* rtl/core/orq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// orq_ctrl
// Sequencer of the ordered ready queue: dispatches each item and steps the
// datapath through the tail-to-head insert walk, the pop shift and the
// lookup scan, one stored entry per cycle.
// ----------------------------------------------------------------------------
module orq_ctrl
  import orq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire dp_status_t sts_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_INS_SCAN = 6'b000100,
    S_INS_HEAD = 6'b001000,
    S_POP_SCAN = 6'b010000,
    S_FIND     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.ptr_op  = PTR_HOLD;
    cmd_o.wr_op   = WR_NONE;
    cmd_o.status  = ST_OK;
    cmd_o.cnt_op  = CNT_HOLD;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.cnt_full) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_FULL;
              state_d      = S_IDLE;
            end else if (sts_i.cnt_zero) begin
              cmd_o.wr_op  = WR_FRESH_ZERO;
              cmd_o.finish = 1'b1;
              cmd_o.cnt_op = CNT_INC;
              state_d      = S_IDLE;
            end else begin
              // walk from the tail toward the head
              cmd_o.ptr_op = PTR_TAIL;
              cmd_o.rd_en  = 1'b1;
              state_d      = S_INS_SCAN;
            end
          end
          OP_POP: begin
            if (sts_i.cnt_zero) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_EMPTY;
              state_d      = S_IDLE;
            end else begin
              cmd_o.ptr_op = PTR_ZERO;
              cmd_o.rd_en  = 1'b1;
              state_d      = S_POP_SCAN;
            end
          end
          OP_FIND: begin
            if (sts_i.cnt_zero) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_NOT_FOUND;
              state_d      = S_IDLE;
            end else begin
              cmd_o.ptr_op = PTR_ZERO;
              cmd_o.rd_en  = 1'b1;
              state_d      = S_FIND;
            end
          end
          default: begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_INS_SCAN: begin
        if (sts_i.ahead) begin
          // move the stored entry one slot back; keep walking unless at the head
          cmd_o.wr_op = WR_SHIFT_UP;
          if (sts_i.ptr_zero) begin
            state_d = S_INS_HEAD;
          end else begin
            cmd_o.ptr_op = PTR_DEC;
            cmd_o.rd_en  = 1'b1;
          end
        end else begin
          cmd_o.wr_op  = WR_FRESH_NEXT;
          cmd_o.finish = 1'b1;
          cmd_o.cnt_op = CNT_INC;
          state_d      = S_IDLE;
        end
      end
      S_INS_HEAD: begin
        cmd_o.wr_op  = WR_FRESH_ZERO;
        cmd_o.finish = 1'b1;
        cmd_o.cnt_op = CNT_INC;
        state_d      = S_IDLE;
      end
      S_POP_SCAN: begin
        if (sts_i.ptr_zero) begin
          cmd_o.cap_hit = 1'b1;
        end else begin
          cmd_o.wr_op = WR_SHIFT_DOWN;
        end
        if (sts_i.ptr_last) begin
          cmd_o.finish = 1'b1;
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_IDLE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          cmd_o.rd_en  = 1'b1;
        end
      end
      S_FIND: begin
        if (sts_i.id_match) begin
          cmd_o.cap_hit = 1'b1;
          cmd_o.finish  = 1'b1;
          state_d       = S_IDLE;
        end else if (sts_i.ptr_last) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_NOT_FOUND;
          state_d      = S_IDLE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          cmd_o.rd_en  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/orq_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// orq_datapath
// Entry memory, walk pointer, order compare, entry count and result
// registers of the ordered ready queue.
// ----------------------------------------------------------------------------
module orq_datapath
  import orq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_cmd_t        cmd_i,
  output dp_status_t            sts_o,
  input  wire logic [1:0]       operation_i,
  input  wire logic [ID_W-1:0]  item_id_i,
  input  wire logic [PRI_W-1:0] item_priority_i,
  input  wire logic [REM_W-1:0] item_remaining_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [ID_W-1:0]       out_id_o,
  output logic [PRI_W-1:0]      out_priority_o,
  output logic [REM_W-1:0]      out_remaining_o,
  output logic [OCC_W-1:0]      occupancy_o
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // True when the fresh entry is served ahead of the stored one.
  function automatic logic goes_before(entry_t stored, entry_t fresh);
    logic res;
    if (stored.pri != fresh.pri) begin
      res = (stored.pri < fresh.pri);
    end else if (stored.rem != fresh.rem) begin
      res = (stored.rem > fresh.rem);
    end else begin
      res = (stored.id > fresh.id);
    end
    return res;
  endfunction

  entry_t           mem [QUEUE_DEPTH];
  entry_t           rd_data_q;
  entry_t           fresh_q;
  op_e              op_q;
  entry_t           hit_q, hit_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] count_m1;
  logic             done_q;
  status_e          status_q;
  entry_t           res_q;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign count_m1 = count_q - CNT_W'(1);

  always_comb begin
    case (cmd_i.ptr_op)
      PTR_HOLD: ptr_d = ptr_q;
      PTR_TAIL: ptr_d = count_m1[IDX_W-1:0];
      PTR_ZERO: ptr_d = '0;
      PTR_DEC:  ptr_d = ptr_q - IDX_W'(1);
      PTR_INC:  ptr_d = ptr_q + IDX_W'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = ptr_q + IDX_W'(1);
    wr_data = fresh_q;
    case (cmd_i.wr_op)
      WR_NONE:       wr_en = 1'b0;
      WR_FRESH_NEXT: wr_data = fresh_q;
      WR_SHIFT_UP:   wr_data = rd_data_q;
      WR_SHIFT_DOWN: begin
        wr_addr = ptr_q - IDX_W'(1);
        wr_data = rd_data_q;
      end
      WR_FRESH_ZERO: wr_addr = '0;
      default:       wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[ptr_d];
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.latch) begin
      op_q       <= op_e'(operation_i);
      fresh_q.id  <= item_id_i;
      fresh_q.pri <= item_priority_i;
      fresh_q.rem <= item_remaining_i;
    end
  end

  assign hit_d = cmd_i.cap_hit ? rd_data_q : hit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      hit_q <= '0;
    end else begin
      hit_q <= hit_d;
    end
    if (cmd_i.finish) begin
      status_q <= cmd_i.status;
      res_q    <= hit_d;
    end
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_HOLD: count_d = count_q;
      CNT_INC:  count_d = count_q + CNT_W'(1);
      CNT_DEC:  count_d = count_m1;
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        count_q <= count_d;
      end
      done_q <= cmd_i.finish;
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.cnt_zero = (count_q == '0);
  assign sts_o.cnt_full = (count_q == CNT_W'(QUEUE_DEPTH));
  assign sts_o.ptr_zero = (ptr_q == '0);
  assign sts_o.ptr_last = (CNT_W'(ptr_q) == count_m1);
  assign sts_o.ahead    = goes_before(rd_data_q, fresh_q);
  assign sts_o.id_match = (rd_data_q.id == fresh_q.id);

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign out_id_o        = res_q.id;
  assign out_priority_o  = res_q.pri;
  assign out_remaining_o = res_q.rem;
  assign occupancy_o     = OCC_W'(count_q);

endmodule
`default_nettype wire

/* rtl/core/ordered_ready_queue_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_ready_queue_top
// Ready queue of process entries kept in service order: insert in order,
// pop the head, look up an entry by id.
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  command   operation_i item_id_i item_priority_i        start & !busy
//            item_remaining_i
//  result    status_o out_id_o out_priority_o             done_o, one cycle
//            out_remaining_o occupancy_o
//
//  An item runs through one memory port pair, one stored entry per cycle:
//  insert walks from the tail, shifting entries back; pop shifts entries
//  toward the head; a lookup scans from the head; a full, empty or unknown
//  operation finishes at dispatch.
//  done_o rises the cycle after the last step; busy is low in that cycle, so
//  the next item may be started while the result is shown.
//  Reset clears the entry count; memory contents stay undefined.
//  The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module ordered_ready_queue_top
  import orq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       operation_i,
  input  wire logic [ID_W-1:0]  item_id_i,
  input  wire logic [PRI_W-1:0] item_priority_i,
  input  wire logic [REM_W-1:0] item_remaining_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [ID_W-1:0]       out_id_o,
  output logic [PRI_W-1:0]      out_priority_o,
  output logic [REM_W-1:0]      out_remaining_o,
  output logic [OCC_W-1:0]      occupancy_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  orq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  orq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .item_id_i        (item_id_i),
    .item_priority_i  (item_priority_i),
    .item_remaining_i (item_remaining_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .out_id_o         (out_id_o),
    .out_priority_o   (out_priority_o),
    .out_remaining_o  (out_remaining_o),
    .occupancy_o      (occupancy_o)
  );

endmodule
`default_nettype wire
